// ===== rtl/core/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table.
// No dependencies; used through scoped names by every module but oaht_ram.
package oaht_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int DEF_TABLE_SLOTS = 256;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 64;

  // Fixed field widths of the streaming ports
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int HASH_W    = 32;
  localparam int KEY_IN_W  = 32;
  localparam int VAL_IN_W  = 64;
  localparam int LIMIT_W   = 9;
  localparam int SLOT_ST_W = 2;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 9'd192;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  // Slot state codes
  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_LIVE  = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_TOMB  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/oaht_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/oaht_mod.sv =====
// Reduces a 32-bit key hash to a starting slot index (hash mod slot count).
// Depends on oaht_pkg. Power-of-two slot counts register the low hash bits; others
// register the hash, a reciprocal-multiply estimate, then one conditional subtract.
module oaht_mod #(
  parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
  localparam int IW = $clog2(TABLE_SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [oaht_pkg::HASH_W-1:0] hash_in,
  output logic                        done,
  output logic [IW-1:0]               rem
);

  localparam bit IS_POW2 = (TABLE_SLOTS == (1 << IW));

  generate
    if (IS_POW2) begin : g_mask
      logic          done_r;
      logic [IW-1:0] rem_r;

      // low bits are the remainder
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= hash_in[IW-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_recip
      localparam int HW = oaht_pkg::HASH_W;
      localparam int SH = HW + IW;
      // floor(2^SH / slots): quotient estimate is exact or one below
      localparam logic [HW:0] RECIP = (HW+1)'((64'd1 << SH) / 64'(TABLE_SLOTS));
      localparam logic [IW:0] MODN  = (IW+1)'(TABLE_SLOTS);

      logic          ph1_r, ph2_r, done_r;
      logic [HW-1:0] hash_r;
      logic [IW:0]   quo_r;
      logic [IW-1:0] rem_r;
      logic [2*HW:0] prod;
      logic [IW:0]   est;

      // only the low bits of quotient and remainder matter: the estimate
      // lies below twice the slot count
      assign prod = (2*HW+1)'(hash_r) * (2*HW+1)'(RECIP);
      assign est  = hash_r[IW:0] - (IW+1)'(quo_r * MODN);

      // phase flags
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ph1_r  <= 1'b0;
          ph2_r  <= 1'b0;
          done_r <= 1'b0;
        end else begin
          ph1_r  <= start;
          ph2_r  <= ph1_r;
          done_r <= ph2_r;
        end
      end

      // hash capture, quotient estimate, corrected remainder
      always_ff @(posedge clk) begin
        if (start) begin
          hash_r <= hash_in;
        end
        if (ph1_r) begin
          quo_r <= prod[SH +: IW+1];
        end
        if (ph2_r) begin
          rem_r <= (est >= MODN) ? IW'(est - MODN) : est[IW-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

// ===== rtl/core/open_addressing_hash_table.sv =====
// Open-addressing key/value table with linear probing and tombstones.
// Steps: take the item, reduce the hash (reciprocal path if TABLE_SLOTS is not a power
// of two), probe one slot per cycle (one slot RAM read each), write back and present the
// result once the output register is free; unused commands, and gets or deletes on an
// empty table, skip hash and probe. One item at a time. Synchronous reset, then a clearing
// pass writes every slot empty, taking no item (configuration writes are taken).
module open_addressing_hash_table #(
  parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
  parameter int KEY_BITS    = oaht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = oaht_pkg::DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  // command items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key_id[31:0], key_hash[63:32], write_value[127:64]
  input  logic [1:0]   in_tuser,   // command[1:0]
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // read_value[63:0]
  output logic [2:0]   out_tuser,  // status[1:0], key_was_new[2]
  // load limit register
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data    // load_limit[8:0]
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int SW = oaht_pkg::SLOT_ST_W;
  localparam int W  = SW + KEY_BITS + VALUE_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);

  oaht_pkg::state_t state_r, state_nxt;

  // item being worked on
  logic [oaht_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]        key_r, key_nxt;
  logic [VALUE_BITS-1:0]      val_r, val_nxt;

  // probe walk
  logic [IW-1:0] at_r, at_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          tomb_r, tomb_nxt;
  logic [IW-1:0] tomb_at_r, tomb_at_nxt;

  // pending result and write-back
  logic                          res_we_r, res_we_nxt;
  logic                          res_tomb_r, res_tomb_nxt;
  logic                          res_inc_r, res_inc_nxt;
  logic [IW-1:0]                 res_addr_r, res_addr_nxt;
  logic [oaht_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [63:0]                   res_rd_r, res_rd_nxt;
  logic                          res_new_r, res_new_nxt;

  // table occupancy and limit
  logic [CW-1:0]               used_r, used_nxt;
  logic [oaht_pkg::LIMIT_W-1:0] limit_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        out_free;
  logic        out_load;

  // slot memory and hash unit
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [W-1:0]  ram_rdata;
  logic          mod_start;
  logic          mod_done;
  logic [IW-1:0] mod_rem;

  // probe decode of the slot read last cycle
  logic [SW-1:0]         slot_st;
  logic [KEY_BITS-1:0]   slot_key;
  logic [VALUE_BITS-1:0] slot_val;
  logic                  is_empty, is_hit, is_tomb, is_last, probe_stop;
  logic                  tomb_any;
  logic                  room_ok;
  logic [IW-1:0]         tomb_pick;
  logic                  in_acc;
  logic                  need_probe;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == oaht_pkg::ST_DONE) && out_free;

  assign slot_st    = ram_rdata[W-1 -: SW];
  assign slot_key   = ram_rdata[VALUE_BITS +: KEY_BITS];
  assign slot_val   = ram_rdata[VALUE_BITS-1:0];
  assign is_empty   = (slot_st == oaht_pkg::SLOT_EMPTY);
  assign is_hit     = (slot_st == oaht_pkg::SLOT_LIVE) && (slot_key == key_r);
  assign is_tomb    = (slot_st == oaht_pkg::SLOT_TOMB);
  assign is_last    = (cnt_r == LAST_IDX);
  assign probe_stop = is_empty || is_hit || is_last;
  assign tomb_any   = tomb_r || is_tomb;
  assign tomb_pick  = tomb_r ? tomb_at_r : at_r;
  assign room_ok    = 32'(used_r) < 32'(limit_r);

  // set always probes; get and delete probe only a non-empty table
  assign need_probe = (in_tuser == oaht_pkg::CMD_SET) ||
                      (((in_tuser == oaht_pkg::CMD_GET) || (in_tuser == oaht_pkg::CMD_DEL)) &&
                       (used_r != '0));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oaht_pkg::ST_CLEAR: if (at_r == LAST_IDX) state_nxt = oaht_pkg::ST_IDLE;
      oaht_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = need_probe ? oaht_pkg::ST_HASH : oaht_pkg::ST_DONE;
      end
      oaht_pkg::ST_HASH: if (mod_done) state_nxt = oaht_pkg::ST_PROBE;
      oaht_pkg::ST_PROBE: if (probe_stop) state_nxt = oaht_pkg::ST_DONE;
      oaht_pkg::ST_DONE: if (out_free) state_nxt = oaht_pkg::ST_IDLE;
      default: state_nxt = oaht_pkg::ST_CLEAR;
    endcase
  end

  // state outputs: handshake, hash start, memory write port
  always_comb begin
    in_tready = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = res_addr_r;
    ram_wdata = res_tomb_r ? {oaht_pkg::SLOT_TOMB, {(KEY_BITS + VALUE_BITS){1'b0}}}
                           : {oaht_pkg::SLOT_LIVE, key_r, val_r};
    unique case (state_r)
      oaht_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = at_r;
        ram_wdata = {oaht_pkg::SLOT_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
      end
      oaht_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mod_start = in_acc && need_probe;
      end
      oaht_pkg::ST_HASH: ;
      oaht_pkg::ST_PROBE: ;
      oaht_pkg::ST_DONE: ram_we = res_we_r && out_free;
      default: ;
    endcase
  end

  // datapath: item capture, probe walk, result decision
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    at_nxt         = at_r;
    cnt_nxt        = cnt_r;
    tomb_nxt       = tomb_r;
    tomb_at_nxt    = tomb_at_r;
    res_we_nxt     = res_we_r;
    res_tomb_nxt   = res_tomb_r;
    res_inc_nxt    = res_inc_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    res_new_nxt    = res_new_r;
    used_nxt       = used_r;

    unique case (state_r)
      oaht_pkg::ST_CLEAR: at_nxt = (at_r == LAST_IDX) ? '0 : at_r + 1'b1;
      oaht_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_tuser;
          key_nxt        = KEY_BITS'(in_tdata[31:0]);
          val_nxt        = VALUE_BITS'(in_tdata[127:64]);
          // short answer for an empty table or an unused command
          res_we_nxt     = 1'b0;
          res_tomb_nxt   = 1'b0;
          res_inc_nxt    = 1'b0;
          res_status_nxt = oaht_pkg::STAT_MISS;
          res_rd_nxt     = '0;
          res_new_nxt    = 1'b0;
        end
      end
      oaht_pkg::ST_HASH: begin
        if (mod_done) begin
          at_nxt   = mod_rem;
          cnt_nxt  = '0;
          tomb_nxt = 1'b0;
        end
      end
      oaht_pkg::ST_PROBE: begin
        if (is_tomb && !tomb_r) begin
          tomb_nxt    = 1'b1;
          tomb_at_nxt = at_r;
        end
        if (!probe_stop) begin
          at_nxt  = (at_r == LAST_IDX) ? '0 : at_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          res_we_nxt     = 1'b0;
          res_tomb_nxt   = 1'b0;
          res_inc_nxt    = 1'b0;
          res_addr_nxt   = at_r;
          res_status_nxt = oaht_pkg::STAT_MISS;
          res_rd_nxt     = '0;
          res_new_nxt    = 1'b0;
          priority if (cmd_r == oaht_pkg::CMD_SET) begin
            priority if (is_hit) begin
              res_we_nxt     = 1'b1;
              res_status_nxt = oaht_pkg::STAT_OK;
            end else if (tomb_any) begin
              res_we_nxt     = 1'b1;
              res_addr_nxt   = tomb_pick;
              res_status_nxt = oaht_pkg::STAT_OK;
              res_new_nxt    = 1'b1;
            end else if (is_empty && room_ok) begin
              res_we_nxt     = 1'b1;
              res_inc_nxt    = (used_r != FULL_CNT);
              res_status_nxt = oaht_pkg::STAT_OK;
              res_new_nxt    = 1'b1;
            end else begin
              res_status_nxt = oaht_pkg::STAT_FULL;
            end
          end else if (is_hit) begin
            res_status_nxt = oaht_pkg::STAT_OK;
            if (cmd_r == oaht_pkg::CMD_GET) begin
              res_rd_nxt = 64'(slot_val);
            end else begin
              res_we_nxt   = 1'b1;
              res_tomb_nxt = 1'b1;
            end
          end
        end
      end
      oaht_pkg::ST_DONE: begin
        if (out_free && res_inc_r) used_nxt = used_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register: a held result stalls the next item only at write-back, until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaht_pkg::ST_CLEAR;
      at_r        <= '0;
      used_r      <= '0;
      limit_r     <= oaht_pkg::LOAD_LIMIT_RST;
      out_valid_r <= 1'b0;
      res_we_r    <= 1'b0;
      res_inc_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      at_r        <= at_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      res_we_r    <= res_we_nxt;
      res_inc_r   <= res_inc_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cnt_r        <= cnt_nxt;
    tomb_r       <= tomb_nxt;
    tomb_at_r    <= tomb_at_nxt;
    res_tomb_r   <= res_tomb_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    res_new_r    <= res_new_nxt;
    if (out_load) begin
      out_data_r <= res_rd_r;
      out_user_r <= {res_new_r, res_status_r};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // hash reduction
  oaht_mod #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .hash_in(in_tdata[63:32]),
    .done   (mod_done),
    .rem    (mod_rem)
  );

  // slot store: {state, key, value}; read address follows the next probe index
  oaht_ram #(
    .WIDTH(W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(at_nxt),
    .rdata(ram_rdata)
  );

  // slot store is written only by the clearing pass or at write-back
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == oaht_pkg::ST_CLEAR || state_r == oaht_pkg::ST_DONE))
    else $error("slot write outside clear or write-back");

  // occupancy never passes the slot count
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT)
    else $error("used count above slot count");

  // occupancy grows by at most one per item and never drops
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (used_r == $past(used_r) || used_r == $past(used_r) + 1'b1))
    else $error("used count jumped");

  // a new result appears only from write-back
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == oaht_pkg::ST_DONE)
    else $error("result raised outside write-back");

  // a key hit ends the probe
  a_hit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oaht_pkg::ST_PROBE && is_hit) |=> state_r == oaht_pkg::ST_DONE)
    else $error("probe continued past a hit");

endmodule

// ===== sim/tb_open_addressing_hash_table.sv =====
// Self-checking testbench for open_addressing_hash_table: a shadow table predicts
// every result item, random stalls on both stream sides. Depends on oaht_pkg.
// Directed probing corner cases first, then random set/get/delete traffic.
module tb_open_addressing_hash_table;

  localparam int SLOTS = oaht_pkg::DEF_TABLE_SLOTS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int POOL_KEYS = 96;
  localparam logic [oaht_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [oaht_pkg::STATUS_W-1:0] status;
    logic [63:0]                   read_value;
    logic                          key_was_new;
  } reply_t;

  // Shadow copy of the slot table; predicts one reply per command
  class table_shadow;
    logic [oaht_pkg::SLOT_ST_W-1:0] slot_state [SLOTS];
    bit [31:0]                      slot_key [SLOTS];
    bit [63:0]                      slot_value [SLOTS];
    int unsigned                    used_count;
    bit [oaht_pkg::LIMIT_W-1:0]     load_limit;
    reply_t                         pending_replies [$];
    int                             mismatches;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = oaht_pkg::SLOT_EMPTY;
      end
      used_count = 0;
      load_limit = oaht_pkg::LOAD_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void set_load_limit(bit [oaht_pkg::LIMIT_W-1:0] limit);
      load_limit = limit;
    endfunction

    // Linear probe: stops on empty slot or key hit, notes first tombstone
    function void walk(input bit [31:0] key, input bit [31:0] hash,
                       output bit hit, output int hit_at,
                       output bit tomb, output int tomb_at,
                       output bit empty, output int empty_at);
      int at;
      hit = 1'b0;
      tomb = 1'b0;
      empty = 1'b0;
      hit_at = 0;
      tomb_at = 0;
      empty_at = 0;
      at = hash % SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_state[at] == oaht_pkg::SLOT_EMPTY) begin
          empty = 1'b1;
          empty_at = at;
          return;
        end
        if (slot_state[at] == oaht_pkg::SLOT_LIVE) begin
          if (slot_key[at] == key) begin
            hit = 1'b1;
            hit_at = at;
            return;
          end
        end else if (!tomb) begin
          tomb = 1'b1;
          tomb_at = at;
        end
        at = (at + 1) % SLOTS;
      end
    endfunction

    function void take_command(logic [oaht_pkg::CMD_W-1:0] cmd, bit [31:0] key,
                               bit [31:0] hash, bit [63:0] value);
      reply_t r;
      bit hit, tomb, empty;
      int hit_at, tomb_at, empty_at;
      r.status = oaht_pkg::STAT_MISS;
      r.read_value = '0;
      r.key_was_new = 1'b0;
      case (cmd)
        oaht_pkg::CMD_SET: begin
          walk(key, hash, hit, hit_at, tomb, tomb_at, empty, empty_at);
          if (hit) begin
            slot_value[hit_at] = value;
            r.status = oaht_pkg::STAT_OK;
          end else if (tomb) begin
            slot_state[tomb_at] = oaht_pkg::SLOT_LIVE;
            slot_key[tomb_at] = key;
            slot_value[tomb_at] = value;
            r.status = oaht_pkg::STAT_OK;
            r.key_was_new = 1'b1;
          end else if (empty && used_count < load_limit) begin
            slot_state[empty_at] = oaht_pkg::SLOT_LIVE;
            slot_key[empty_at] = key;
            slot_value[empty_at] = value;
            if (used_count < SLOTS) used_count++;
            r.status = oaht_pkg::STAT_OK;
            r.key_was_new = 1'b1;
          end else begin
            r.status = oaht_pkg::STAT_FULL;
          end
        end
        oaht_pkg::CMD_GET, oaht_pkg::CMD_DEL: begin
          if (used_count != 0) begin
            walk(key, hash, hit, hit_at, tomb, tomb_at, empty, empty_at);
            if (hit) begin
              r.status = oaht_pkg::STAT_OK;
              if (cmd == oaht_pkg::CMD_GET) r.read_value = slot_value[hit_at];
              else slot_state[hit_at] = oaht_pkg::SLOT_TOMB;
            end
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [oaht_pkg::STATUS_W-1:0] status,
                              logic [63:0] read_value, logic key_was_new);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result item: status %0d read_value %h", status, read_value);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, read_value);
        mismatches++;
      end
      if (key_was_new !== want.key_was_new) begin
        $error("key_was_new: expected %0d, actual %0d", want.key_was_new, key_was_new);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [8:0]   cfg_data = '0;

  int   tx_idle_pct = 15;
  int   rx_idle_pct = 83;
  logic rx_hold = 1'b0;
  int   commands_sent = 0;

  bit [31:0] pool_key [POOL_KEYS];
  bit [31:0] pool_hash [POOL_KEYS];

  table_shadow shadow = new();

  open_addressing_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // key_id[31:0], key_hash[63:32], write_value[127:64]
    .in_tuser   (in_tuser),   // command[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // read_value[63:0]
    .out_tuser  (out_tuser),  // status[1:0], key_was_new[2]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // load_limit[8:0]
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random backpressure, check each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) shadow.check_reply(out_tuser[1:0], out_tdata, out_tuser[2]);
      out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off while commands keep coming
  initial begin
    int held;
    wait (commands_sent >= 200);
    @(posedge clk);
    rx_hold <= 1'b1;
    for (held = 0; held < 400; held++) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog
  initial begin
    int unsigned waited;
    for (waited = 0; waited < CYCLE_LIMIT; waited++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic send_command(logic [oaht_pkg::CMD_W-1:0] cmd, bit [31:0] key,
                              bit [31:0] hash, bit [63:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {value, hash, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_command(cmd, key, hash, value);
    commands_sent++;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_load_limit(bit [oaht_pkg::LIMIT_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.set_load_limit(limit);
    cfg_valid <= 1'b0;
  endtask

  // Pool keys (mostly with their own hash) or, at fresh_pct, fresh keys and hashes
  task automatic send_random(int count, int set_pct, int del_pct, int fresh_pct);
    logic [oaht_pkg::CMD_W-1:0] cmd;
    bit [31:0] key, hash;
    int pick, r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 3) cmd = CMD_NONE;
      else if (r < 3 + set_pct) cmd = oaht_pkg::CMD_SET;
      else if (r < 3 + set_pct + del_pct) cmd = oaht_pkg::CMD_DEL;
      else cmd = oaht_pkg::CMD_GET;
      if ($urandom_range(99) < fresh_pct) begin
        key = $urandom;
        hash = $urandom;
      end else begin
        pick = $urandom_range(POOL_KEYS - 1);
        key = pool_key[pick];
        hash = ($urandom_range(19) == 0) ? $urandom : pool_hash[pick];
      end
      send_command(cmd, key, hash, {$urandom, $urandom});
    end
  endtask

  initial begin
    bit [63:0] ones;
    ones = '1;
    // pool hashes keep bit 7 low so keys crowd half the table
    foreach (pool_key[i]) begin
      pool_key[i] = $urandom;
      pool_hash[i] = $urandom & 32'hFFFF_FF7F;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, nothing may be stored
    write_load_limit(9'd0);
    send_command(oaht_pkg::CMD_GET, 32'h0, 32'h0, 64'h0);
    send_command(oaht_pkg::CMD_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ones);
    send_command(oaht_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ones);
    send_command(CMD_NONE, 32'h5A5A_A5A5, 32'h0000_0010, ones);
    drain_replies();

    // insert, overwrite, collide, tombstones, stale hash, load limit
    write_load_limit(9'd8);
    send_command(oaht_pkg::CMD_SET, 32'h0, 32'h10, ones);
    send_command(oaht_pkg::CMD_SET, 32'h0, 32'h10, 64'h0);
    send_command(oaht_pkg::CMD_GET, 32'h0, 32'h10, ones);
    send_command(oaht_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h8000_0010, 64'h0123_4567_89AB_CDEF);
    send_command(oaht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h10, 64'h0);
    send_command(oaht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h12, 64'h0);
    send_command(oaht_pkg::CMD_DEL, 32'h0, 32'h10, 64'h0);
    send_command(oaht_pkg::CMD_GET, 32'h0, 32'h10, 64'h0);
    send_command(oaht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h10, 64'h0);
    send_command(oaht_pkg::CMD_SET, 32'h5, 32'h10, 64'hFEDC_BA98_7654_3210);
    send_command(oaht_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h13, 64'h1);
    send_command(oaht_pkg::CMD_DEL, 32'h1234, 32'h10, 64'h0);
    for (int k = 100; k < 105; k++) begin
      send_command(oaht_pkg::CMD_SET, k, 32'hFFFF_FFFF, {2{$urandom}});
    end
    send_command(oaht_pkg::CMD_SET, 32'd105, 32'hFF, 64'h2);
    send_command(oaht_pkg::CMD_DEL, 32'd102, 32'hFF, 64'h0);
    send_command(oaht_pkg::CMD_SET, 32'd105, 32'hFF, 64'h3);
    send_command(oaht_pkg::CMD_GET, 32'd104, 32'h7FFF_FFFF, 64'h0);
    drain_replies();

    // churn at the reset limit, sender rarely idle, receiver mostly stalled
    write_load_limit(oaht_pkg::LOAD_LIMIT_RST);
    send_random(450, 40, 17, 10);
    drain_replies();

    // roles swapped, random limit
    tx_idle_pct = 83;
    rx_idle_pct = 15;
    write_load_limit(9'($urandom_range(256)));
    send_random(450, 40, 17, 10);
    drain_replies();

    // full capacity: fill every slot, then no room
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_load_limit(9'd256);
    send_random(300, 80, 5, 80);
    drain_replies();

    write_load_limit(9'h1FF);
    send_random(60, 40, 20, 30);
    drain_replies();

    repeat (300) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/oaht_pkg.sv
rtl/core/oaht_ram.sv
rtl/core/oaht_mod.sv
rtl/core/open_addressing_hash_table.sv
sim/tb_open_addressing_hash_table.sv
